// ===== src/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// Diffusive time step limit: shared definitions
// Default number format and the codes of the configuration registers.
// ----------------------------------------------------------------------------
package dts_pkg;

  parameter int unsigned FRAC_BITS_DEF   = 28;
  parameter int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KIN_VISC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_MODE = 1'b1;

  localparam int unsigned  DIM_W  = 2;
  localparam logic [1:0]   DIM_2D = 2'd2;
  localparam logic [1:0]   DIM_3D = 2'd3;

endpackage

// ===== src/dts_cell_if.sv =====
// ----------------------------------------------------------------------------
// Diffusive time step limit: cell channel
// Carries one grid cell per beat: mesh widths, eddy viscosity and start flag.
// ----------------------------------------------------------------------------
interface dts_cell_if #(
  parameter int unsigned VALUE_WIDTH = dts_pkg::VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] width_x;
  logic [VALUE_WIDTH-1:0] width_y;
  logic [VALUE_WIDTH-1:0] width_z;
  logic [VALUE_WIDTH-1:0] eddy_viscosity;
  logic                   start_sweep;

  modport source (
    output valid, width_x, width_y, width_z, eddy_viscosity, start_sweep,
    input  ready
  );

  modport sink (
    input  valid, width_x, width_y, width_z, eddy_viscosity, start_sweep,
    output ready
  );
endinterface

// ----------------------------------------------------------------------------
// Diffusive time step limit: step channel
// Carries one result per beat: the cell limit and the running minimum.
// ----------------------------------------------------------------------------
interface dts_step_if #(
  parameter int unsigned VALUE_WIDTH = dts_pkg::VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] cell_step;
  logic [VALUE_WIDTH-1:0] min_step;

  modport source (
    output valid, cell_step, min_step,
    input  ready
  );

  modport sink (
    input  valid, cell_step, min_step,
    output ready
  );
endinterface

// ===== src/diffusive_time_step_min_core.sv =====
// ----------------------------------------------------------------------------
// Diffusive time step limit with running minimum
// Computes the diffusive stability limit of one grid cell per beat on a single
// shared multiplier and a radix-2 divider, and folds it into a running minimum.
// ----------------------------------------------------------------------------
// Usage:
// A cell beat on cell_i carries the widths dx, dy, dz and the eddy viscosity.
// Each cell gives exactly one beat on step_o with the cell limit and the
// running minimum after that cell; a set start flag reloads the minimum with
// one before the cell is folded in.
// The cell is worked through as a list of terms, each a product formed in
// two passes of a VALUE_WIDTH by half-width multiplier followed by a restoring
// division of one quotient bit per cycle; the division is skipped when the
// quotient saturates. A 2D cell has four terms and a 3D cell seven.
// cell_i is ready only while no cell is in work. The next cell can be accepted
// in the cycle after the result is loaded, so a new cell is never taken before
// the last one has its result.
// A finished result waits in the output register while the next cell is
// accepted; if the receiver stalls, the following result waits in the finish
// state until the register frees.
// Reset clears both channels, sets the kinematic viscosity to zero, the
// dimension mode to 2D and the running minimum to one.
// ----------------------------------------------------------------------------
module diffusive_time_step_min_core #(
  parameter int unsigned FRAC_BITS   = dts_pkg::FRAC_BITS_DEF,
  parameter int unsigned VALUE_WIDTH = dts_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dts_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0]        cfg_data_i,
  dts_cell_if.sink                      cell_i,
  dts_step_if.source                    step_o
);
  import dts_pkg::*;

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned H    = (W + 1) / 2;
  localparam int unsigned DW   = 2 * W + 1;
  localparam int unsigned SE   = 3 * FRAC_BITS - W;
  localparam int unsigned RW   = ((DW > SE + 1) ? DW : SE + 1) + 1;
  localparam int unsigned CNTW = $clog2(W);

  localparam logic [W-1:0]    MAXV     = '1;
  localparam logic [W-1:0]    ONE_VAL  = (FRAC_BITS < W) ? (W'(1) << FRAC_BITS) : MAXV;
  localparam logic [RW-1:0]   SAT_LIM  = RW'(1) << SE;
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(W - 1);

  localparam logic [2:0] TERM_XX = 3'd0;
  localparam logic [2:0] TERM_YY = 3'd1;
  localparam logic [2:0] TERM_ZZ = 3'd2;
  localparam logic [2:0] TERM_XY = 3'd3;
  localparam logic [2:0] TERM_XZ = 3'd4;
  localparam logic [2:0] TERM_YZ = 3'd5;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL_LO = 7'b0000010,
    ST_MUL_HI = 7'b0000100,
    ST_CHECK  = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_ACC    = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [W-1:0]    kin_visc_q, kin_visc_d;
  logic [1:0]      dim_q, dim_d;
  logic [W-1:0]    min_q, min_d;
  logic            out_valid_q, out_valid_d;
  logic [W-1:0]    cell_q, cell_d;

  logic [2:0]      term_q, term_d;
  logic            final_q, final_d;
  logic            start_q, start_d;
  logic [W-1:0]    wx_q, wx_d, wy_q, wy_d, wz_q, wz_d;
  logic [W-1:0]    visc_q, visc_d;
  logic [W-1:0]    fac_q, fac_d;
  logic [W-1:0]    mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic [DW-1:0]   d_q, d_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  logic            three_d;
  logic [H-1:0]    mul_b_part;
  logic [W+H-1:0]  prod;
  logic [DW-1:0]   prod_sum;
  logic [RW-1:0]   rem_sh;
  logic            rem_ge;
  logic [W:0]      visc_sum;
  logic [W:0]      fac_sum;
  logic [W-1:0]    fac_new;
  logic [W-1:0]    min_base;
  logic            last_term;
  logic [2:0]      next_term;
  logic [W-1:0]    op_a, op_b;

  assign three_d = (dim_q == DIM_3D);

  assign mul_b_part = (state_q == ST_MUL_LO) ? mul_b_q[H-1:0] : H'(mul_b_q[W-1:H]);
  assign prod       = (W+H)'(mul_a_q) * (W+H)'(mul_b_part);
  assign prod_sum   = d_q + (DW'(prod) << H);

  assign rem_sh = {rem_q[RW-2:0], 1'b0};
  assign rem_ge = (rem_sh >= RW'(d_q));

  assign visc_sum = {1'b0, kin_visc_q} + {1'b0, cell_i.eddy_viscosity};
  assign fac_sum  = {1'b0, fac_q} + {1'b0, quo_q};
  assign fac_new  = fac_sum[W] ? MAXV : fac_sum[W-1:0];
  assign min_base = start_q ? ONE_VAL : min_q;

  always_comb begin
    last_term = 1'b0;
    next_term = term_q;
    if (three_d) begin
      if (term_q == TERM_YZ) begin
        last_term = 1'b1;
      end else begin
        next_term = term_q + 3'd1;
      end
    end else begin
      case (term_q)
        TERM_XX: next_term = TERM_YY;
        TERM_YY: next_term = TERM_XY;
        default: last_term = 1'b1;
      endcase
    end
  end

  always_comb begin
    case (next_term)
      TERM_YY: begin
        op_a = wy_q;
        op_b = wy_q;
      end
      TERM_ZZ: begin
        op_a = wz_q;
        op_b = wz_q;
      end
      TERM_XY: begin
        op_a = wx_q;
        op_b = wy_q;
      end
      TERM_XZ: begin
        op_a = wx_q;
        op_b = wz_q;
      end
      TERM_YZ: begin
        op_a = wy_q;
        op_b = wz_q;
      end
      default: begin
        op_a = wx_q;
        op_b = wx_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    kin_visc_d  = kin_visc_q;
    dim_d       = dim_q;
    min_d       = min_q;
    out_valid_d = out_valid_q && !step_o.ready;
    cell_d      = cell_q;
    term_d      = term_q;
    final_d     = final_q;
    start_d     = start_q;
    wx_d        = wx_q;
    wy_d        = wy_q;
    wz_d        = wz_q;
    visc_d      = visc_q;
    fac_d       = fac_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    d_d         = d_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KIN_VISC: kin_visc_d = cfg_data_i;
        REG_DIM_MODE: dim_d      = cfg_data_i[DIM_W-1:0];
        default:      ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (cell_i.valid) begin
          wx_d    = cell_i.width_x;
          wy_d    = cell_i.width_y;
          wz_d    = cell_i.width_z;
          start_d = cell_i.start_sweep;
          visc_d  = visc_sum[W] ? MAXV : visc_sum[W-1:0];
          fac_d   = '0;
          term_d  = TERM_XX;
          final_d = 1'b0;
          mul_a_d = cell_i.width_x;
          mul_b_d = cell_i.width_x;
          state_d = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        d_d     = DW'(prod);
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        d_d     = final_q ? (prod_sum << 1) : prod_sum;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (RW'(d_q) <= SAT_LIM) begin
          quo_d   = MAXV;
          state_d = ST_ACC;
        end else begin
          rem_d   = SAT_LIM;
          quo_d   = '0;
          cnt_d   = CNT_LAST;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = rem_ge ? (rem_sh - RW'(d_q)) : rem_sh;
        quo_d = {quo_q[W-2:0], rem_ge};
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == '0) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (final_q) begin
          state_d = ST_FINISH;
        end else begin
          fac_d   = fac_new;
          term_d  = next_term;
          state_d = ST_MUL_LO;
          if (last_term) begin
            final_d = 1'b1;
            mul_a_d = visc_q;
            mul_b_d = fac_new;
          end else begin
            mul_a_d = op_a;
            mul_b_d = op_b;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || step_o.ready) begin
          cell_d      = quo_q;
          min_d       = (quo_q < min_base) ? quo_q : min_base;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kin_visc_q  <= '0;
      dim_q       <= DIM_2D;
      min_q       <= ONE_VAL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kin_visc_q  <= kin_visc_d;
      dim_q       <= dim_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q  <= cell_d;
    term_q  <= term_d;
    final_q <= final_d;
    start_q <= start_d;
    wx_q    <= wx_d;
    wy_q    <= wy_d;
    wz_q    <= wz_d;
    visc_q  <= visc_d;
    fac_q   <= fac_d;
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    d_q     <= d_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
  end

  assign cell_i.ready     = (state_q == ST_IDLE);
  assign step_o.valid     = out_valid_q;
  assign step_o.cell_step = cell_q;
  assign step_o.min_step  = min_q;

endmodule
